FILE: sv/srw_pkg.sv
// ----------------------------------------------------------------------------
// Sequence reorder window package
// Shared types, codes and widths for the sequence reorder window unit.
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int SEQ_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int FLAG_W   = 8;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 13;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_GET      = 3'd0;
    localparam t_mode MODE_PUT      = 3'd1;
    localparam t_mode MODE_AND      = 3'd2;
    localparam t_mode MODE_OR       = 3'd3;
    localparam t_mode MODE_POP      = 3'd4;
    localparam t_mode MODE_POP_FULL = 3'd5;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_BELOW    = 3'd1;
    localparam t_status ST_ABOVE    = 3'd2;
    localparam t_status ST_OCCUPIED = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOCATE,
        S_READ,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic locate;
        logic read;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

FILE: sv/srw_ctrl.sv
// ----------------------------------------------------------------------------
// Sequence reorder window controller
// Steps each beat through locate, slot read and execute phases.
// ----------------------------------------------------------------------------
module srw_ctrl
    import srw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOCATE;
                end
            end
            S_LOCATE: n_state = S_READ;
            S_READ:   n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_LOCATE: o_cmd.locate = 1'b1;
            S_READ:   o_cmd.read = 1'b1;
            S_EXEC:   o_cmd.exec = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

FILE: sv/srw_datapath.sv
// ----------------------------------------------------------------------------
// Sequence reorder window datapath
// Window registers, slot memories, occupancy count and result register.
// ----------------------------------------------------------------------------
module srw_datapath
    import srw_pkg::*;
#(
    parameter int WINDOW_SIZE = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_cfg_we,
    input  logic [SEQ_W-1:0]    i_cfg_data,
    input  t_mode               i_mode,
    input  logic [SEQ_W-1:0]    i_seq_num,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_handle_present,
    input  logic [FLAG_W-1:0]   i_flag_mask,
    output logic                o_valid,
    input  logic                i_ready,
    output t_status             o_status,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic                o_out_handle_valid,
    output logic [FLAG_W-1:0]   o_old_flags,
    output logic [SEQ_W-1:0]    o_tail_seq,
    output logic [COUNT_W-1:0]  o_occupied_count
);

    localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    logic [HANDLE_W-1:0] mem_handle [WINDOW_SIZE];
    logic [FLAG_W-1:0]   mem_flags  [WINDOW_SIZE];

    logic [WINDOW_SIZE-1:0] r_slot_valid;
    logic [WINDOW_SIZE-1:0] r_flag_wr;

    t_mode               r_mode;
    logic [SEQ_W-1:0]    r_seq;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_present;
    logic [FLAG_W-1:0]   r_mask;

    logic [SEQ_W-1:0]    r_tseq;
    logic [IW-1:0]       r_tail;
    logic [COUNT_W-1:0]  r_count;

    t_status             r_err;
    logic [IW-1:0]       r_off;
    logic [IW-1:0]       r_addr;
    logic [HANDLE_W-1:0] r_rd_handle;
    logic [FLAG_W-1:0]   r_rd_flags;
    logic                r_rd_valid;
    logic                r_rd_fwr;

    logic                r_out_valid;
    t_status             r_o_status;
    logic [HANDLE_W-1:0] r_o_handle;
    logic                r_o_handle_valid;
    logic [FLAG_W-1:0]   r_o_flags;
    logic [SEQ_W-1:0]    r_o_tseq;
    logic [COUNT_W-1:0]  r_o_count;

    logic [SEQ_W-1:0]    off;
    logic [IW:0]         pos_sum;
    logic [IW-1:0]       n_addr;

    logic                slot_full;
    logic [FLAG_W-1:0]   cur_flags;
    logic                do_pop;
    logic                set_valid;
    logic                clr_valid;
    logic                wr_flags;
    logic [FLAG_W-1:0]   new_flags;
    t_status             n_status;
    logic [HANDLE_W-1:0] n_handle;
    logic                n_handle_valid;
    logic [FLAG_W-1:0]   n_old_flags;
    logic [SEQ_W-1:0]    n_tseq;
    logic [IW-1:0]       n_tail;
    logic [COUNT_W-1:0]  n_count;

    assign o_sts.out_free = !r_out_valid || i_ready;

    assign off = r_seq - r_tseq;

    always_comb begin
        pos_sum = {1'b0, r_tail} + {1'b0, r_off};
        if (pos_sum >= (IW+1)'(WINDOW_SIZE)) begin
            pos_sum = pos_sum - (IW+1)'(WINDOW_SIZE);
        end
        if (r_mode == MODE_POP || r_mode == MODE_POP_FULL) begin
            n_addr = r_tail;
        end else begin
            n_addr = pos_sum[IW-1:0];
        end
    end

    always_comb begin
        slot_full      = r_rd_valid;
        cur_flags      = r_rd_fwr ? r_rd_flags : '0;
        do_pop         = 1'b0;
        set_valid      = 1'b0;
        clr_valid      = 1'b0;
        wr_flags       = 1'b0;
        new_flags      = cur_flags & r_mask;
        n_status       = ST_OK;
        n_handle       = '0;
        n_handle_valid = 1'b0;
        n_old_flags    = '0;
        case (r_mode)
            MODE_GET: begin
                n_status = r_err;
                if (r_err == ST_OK && slot_full) begin
                    n_handle       = r_rd_handle;
                    n_handle_valid = 1'b1;
                end
            end
            MODE_PUT: begin
                n_status = r_err;
                if (r_err == ST_OK) begin
                    if (!slot_full) begin
                        set_valid = r_present;
                    end else begin
                        n_status  = ST_OCCUPIED;
                        clr_valid = !r_present;
                    end
                end
            end
            MODE_AND, MODE_OR: begin
                n_status = r_err;
                if (r_err == ST_OK) begin
                    n_old_flags = cur_flags;
                    wr_flags    = 1'b1;
                    new_flags   = (r_mode == MODE_AND) ? (cur_flags & r_mask)
                                                       : (cur_flags | r_mask);
                end
            end
            MODE_POP: do_pop = 1'b1;
            MODE_POP_FULL: begin
                if (slot_full) begin
                    do_pop = 1'b1;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            default: n_status = ST_OK;
        endcase
        if (do_pop && slot_full) begin
            n_handle       = r_rd_handle;
            n_handle_valid = 1'b1;
            clr_valid      = 1'b1;
        end
        n_count = r_count;
        if (set_valid) begin
            n_count = r_count + COUNT_W'(1);
        end else if (clr_valid) begin
            n_count = r_count - COUNT_W'(1);
        end
        n_tseq = r_tseq;
        n_tail = r_tail;
        if (do_pop) begin
            n_tseq = r_tseq + SEQ_W'(1);
            n_tail = (r_tail == IW'(WINDOW_SIZE - 1)) ? '0 : r_tail + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_seq     <= i_seq_num;
            r_handle  <= i_handle;
            r_present <= i_handle_present;
            r_mask    <= i_flag_mask;
        end
        if (i_cmd.locate) begin
            r_off <= off[IW-1:0];
            if (off[SEQ_W-1]) begin
                r_err <= ST_BELOW;
            end else if (off >= SEQ_W'(WINDOW_SIZE)) begin
                r_err <= ST_ABOVE;
            end else begin
                r_err <= ST_OK;
            end
        end
        if (i_cmd.read) begin
            r_addr      <= n_addr;
            r_rd_handle <= mem_handle[n_addr];
            r_rd_flags  <= mem_flags[n_addr];
            r_rd_valid  <= r_slot_valid[n_addr];
            r_rd_fwr    <= r_flag_wr[n_addr];
        end
        if (i_cmd.exec) begin
            if (set_valid) begin
                mem_handle[r_addr] <= r_handle;
            end
            if (wr_flags) begin
                mem_flags[r_addr] <= new_flags;
            end
            r_o_status       <= n_status;
            r_o_handle       <= n_handle;
            r_o_handle_valid <= n_handle_valid;
            r_o_flags        <= n_old_flags;
            r_o_tseq         <= n_tseq;
            r_o_count        <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_flag_wr    <= '0;
            r_tseq       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                if (set_valid) begin
                    r_slot_valid[r_addr] <= 1'b1;
                end else if (clr_valid) begin
                    r_slot_valid[r_addr] <= 1'b0;
                end
                if (wr_flags) begin
                    r_flag_wr[r_addr] <= 1'b1;
                end else if (do_pop) begin
                    r_flag_wr[r_addr] <= 1'b0;
                end
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_tseq <= i_cfg_data + SEQ_W'(r_tail);
            end else if (i_cmd.exec) begin
                r_tseq <= n_tseq;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_o_status;
    assign o_out_handle       = r_o_handle;
    assign o_out_handle_valid = r_o_handle_valid;
    assign o_old_flags        = r_o_flags;
    assign o_tail_seq         = r_o_tseq;
    assign o_occupied_count   = r_o_count;

endmodule

FILE: sv/sequence_reorder_window_unit.sv
// ----------------------------------------------------------------------------
// Sequence reorder window unit
// Circular reorder window of handles and flag bytes keyed by sequence number.
// ----------------------------------------------------------------------------
// Each beat passes in turn through the locate, slot memory read and execute
// phases; its result is registered in execute, which waits while the output
// register holds an untaken result. A new beat is accepted once the last has
// left execute, also while an earlier result still waits in the output register.
// Reset: synchronous, active low; it empties the window, zeroes the flags and
// count, and sets the tail sequence to zero, with no clearing pass.
module sequence_reorder_window_unit
    import srw_pkg::*;
#(
    parameter int WINDOW_SIZE = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SEQ_W-1:0]    i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [SEQ_W-1:0]    i_seq_num,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_handle_present,
    input  logic [FLAG_W-1:0]   i_flag_mask,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic                o_out_handle_valid,
    output logic [FLAG_W-1:0]   o_old_flags,
    output logic [SEQ_W-1:0]    o_tail_seq,
    output logic [COUNT_W-1:0]  o_occupied_count
);

    t_cmd cmd;
    t_sts sts;

    srw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    srw_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_mode             (i_mode),
        .i_seq_num          (i_seq_num),
        .i_handle           (i_handle),
        .i_handle_present   (i_handle_present),
        .i_flag_mask        (i_flag_mask),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_out_handle       (o_out_handle),
        .o_out_handle_valid (o_out_handle_valid),
        .o_old_flags        (o_old_flags),
        .o_tail_seq         (o_tail_seq),
        .o_occupied_count   (o_occupied_count)
    );

endmodule

FILE: sim/srw_window_checker.sv
// ----------------------------------------------------------------------------
// Sequence reorder window checker
// Watches the input, output and configuration ports of the reorder window.
// It predicts each result from its own copy of the window state and
// compares every output beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module srw_window_checker
    import srw_pkg::*;
#(
    parameter int WINDOW_SIZE = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SEQ_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [SEQ_W-1:0]    i_seq_num,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_handle_present,
    input  logic [FLAG_W-1:0]   i_flag_mask,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [HANDLE_W-1:0] i_out_handle,
    input  logic                i_out_handle_valid,
    input  logic [FLAG_W-1:0]   i_old_flags,
    input  logic [SEQ_W-1:0]    i_tail_seq,
    input  logic [COUNT_W-1:0]  i_occupied_count,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(WINDOW_SIZE);

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic                handle_valid;
        logic [FLAG_W-1:0]   flags;
        logic [SEQ_W-1:0]    tail;
        logic [COUNT_W-1:0]  count;
    } t_window_result;

    logic [SEQ_W-1:0]    window_base;
    logic [IDX_W-1:0]    tail_slot;
    logic                slot_full  [WINDOW_SIZE];
    logic [HANDLE_W-1:0] slot_hdl   [WINDOW_SIZE];
    logic [FLAG_W-1:0]   slot_flg   [WINDOW_SIZE];
    int                  fill_level;
    int                  fail_total = 0;
    t_window_result      results_due[$];

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_total++;
    endtask

    function automatic logic [SEQ_W-1:0] tail_now();
        return window_base + SEQ_W'(tail_slot);
    endfunction

    function automatic t_status locate_slot(input logic [SEQ_W-1:0] seq,
                                            output logic [IDX_W-1:0] slot);
        logic [SEQ_W-1:0] off;
        off  = seq - tail_now();
        slot = '0;
        if (off[SEQ_W-1]) begin
            return ST_BELOW;
        end
        if (off >= SEQ_W'(WINDOW_SIZE)) begin
            return ST_ABOVE;
        end
        slot = IDX_W'((int'(tail_slot) + int'(off)) % WINDOW_SIZE);
        return ST_OK;
    endfunction

    function automatic void pop_tail_slot(inout t_window_result res);
        logic [IDX_W-1:0] t;
        t = tail_slot;
        if (slot_full[t]) begin
            res.handle       = slot_hdl[t];
            res.handle_valid = 1'b1;
            slot_full[t]     = 1'b0;
            if (fill_level > 0) begin
                fill_level--;
            end
        end
        slot_hdl[t] = '0;
        slot_flg[t] = '0;
        if (int'(t) == WINDOW_SIZE - 1) begin
            tail_slot   = '0;
            window_base = window_base + SEQ_W'(WINDOW_SIZE);
        end else begin
            tail_slot = t + 1'b1;
        end
    endfunction

    function automatic t_window_result apply_window_op(
        input logic [MODE_W-1:0]   mode,
        input logic [SEQ_W-1:0]    seq,
        input logic [HANDLE_W-1:0] hdl,
        input logic                present,
        input logic [FLAG_W-1:0]   mask
    );
        t_window_result   res;
        logic [IDX_W-1:0] slot;
        res = '0;
        res.status = ST_OK;
        case (mode)
            MODE_GET: begin
                res.status = locate_slot(seq, slot);
                if (res.status == ST_OK && slot_full[slot]) begin
                    res.handle       = slot_hdl[slot];
                    res.handle_valid = 1'b1;
                end
            end
            MODE_PUT: begin
                res.status = locate_slot(seq, slot);
                if (res.status == ST_OK) begin
                    if (!slot_full[slot]) begin
                        if (present) begin
                            slot_full[slot] = 1'b1;
                            slot_hdl[slot]  = hdl;
                            fill_level++;
                        end
                    end else begin
                        res.status = ST_OCCUPIED;
                        if (!present) begin
                            slot_full[slot] = 1'b0;
                            slot_hdl[slot]  = '0;
                            if (fill_level > 0) begin
                                fill_level--;
                            end
                        end
                    end
                end
            end
            MODE_AND, MODE_OR: begin
                res.status = locate_slot(seq, slot);
                if (res.status == ST_OK) begin
                    res.flags = slot_flg[slot];
                    if (mode == MODE_AND) begin
                        slot_flg[slot] = slot_flg[slot] & mask;
                    end else begin
                        slot_flg[slot] = slot_flg[slot] | mask;
                    end
                end
            end
            MODE_POP: begin
                pop_tail_slot(res);
            end
            MODE_POP_FULL: begin
                if (slot_full[tail_slot]) begin
                    pop_tail_slot(res);
                end else begin
                    res.status = ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
        res.tail  = tail_now();
        res.count = COUNT_W'(fill_level);
        return res;
    endfunction

    task automatic compare_result(input t_window_result got, input t_window_result want);
        if (got.status !== want.status) begin
            report_mismatch("status", 32'(got.status), 32'(want.status));
        end
        if (got.handle !== want.handle) begin
            report_mismatch("out_handle", got.handle, want.handle);
        end
        if (got.handle_valid !== want.handle_valid) begin
            report_mismatch("out_handle_valid", 32'(got.handle_valid), 32'(want.handle_valid));
        end
        if (got.flags !== want.flags) begin
            report_mismatch("old_flags", 32'(got.flags), 32'(want.flags));
        end
        if (got.tail !== want.tail) begin
            report_mismatch("tail_seq", got.tail, want.tail);
        end
        if (got.count !== want.count) begin
            report_mismatch("occupied_count", 32'(got.count), 32'(want.count));
        end
    endtask

    always @(posedge i_clk) begin
        t_window_result got;
        t_window_result want;
        if (!i_rst_n) begin
            window_base = '0;
            tail_slot   = '0;
            fill_level  = 0;
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                slot_full[i] = 1'b0;
                slot_hdl[i]  = '0;
                slot_flg[i]  = '0;
            end
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.status       = i_status;
                got.handle       = i_out_handle;
                got.handle_valid = i_out_handle_valid;
                got.flags        = i_old_flags;
                got.tail         = i_tail_seq;
                got.count        = i_occupied_count;
                if (results_due.size() == 0) begin
                    report_mismatch("result beat with nothing expected", got.tail, '0);
                end else begin
                    want = results_due.pop_front();
                    compare_result(got, want);
                end
            end
            if (i_cfg_we) begin
                window_base = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                results_due.push_back(apply_window_op(i_mode, i_seq_num, i_handle,
                                                      i_handle_present, i_flag_mask));
            end
        end
        o_pending <= results_due.size();
    end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Sequence reorder window testbench
// Drives directed and random window operations into the reorder window with
// random gaps on the input and random stalls on the output, across several
// base sequence settings. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srw_pkg::*;

    localparam t_mode MODE_QUERY       = 3'd6;
    localparam t_mode MODE_SPARE       = 3'd7;
    localparam int    CYCLE_LIMIT      = 1_500_000;
    localparam int    RANDOM_PER_PHASE = 275;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [SEQ_W-1:0]    i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    logic [MODE_W-1:0]   i_mode;
    logic [SEQ_W-1:0]    i_seq_num;
    logic [HANDLE_W-1:0] i_handle;
    logic                i_handle_present;
    logic [FLAG_W-1:0]   i_flag_mask;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_out_handle;
    logic                o_out_handle_valid;
    logic [FLAG_W-1:0]   o_old_flags;
    logic [SEQ_W-1:0]    o_tail_seq;
    logic [COUNT_W-1:0]  o_occupied_count;

    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    logic [SEQ_W-1:0] seen_tail   = '0;
    bit               quiet_input;

    sequence_reorder_window_unit #(
        .WINDOW_SIZE(64)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_seq_num         (i_seq_num),
        .i_handle          (i_handle),
        .i_handle_present  (i_handle_present),
        .i_flag_mask       (i_flag_mask),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_out_handle      (o_out_handle),
        .o_out_handle_valid(o_out_handle_valid),
        .o_old_flags       (o_old_flags),
        .o_tail_seq        (o_tail_seq),
        .o_occupied_count  (o_occupied_count)
    );

    srw_window_checker #(
        .WINDOW_SIZE(64)
    ) checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_mode            (i_mode),
        .i_seq_num         (i_seq_num),
        .i_handle          (i_handle),
        .i_handle_present  (i_handle_present),
        .i_flag_mask       (i_flag_mask),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_status          (o_status),
        .i_out_handle      (o_out_handle),
        .i_out_handle_valid(o_out_handle_valid),
        .i_old_flags       (o_old_flags),
        .i_tail_seq        (o_tail_seq),
        .i_occupied_count  (o_occupied_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (o_valid && i_ready) begin
            seen_tail <= o_tail_seq;
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(25, 80);
    endfunction

    initial begin
        int run;
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                run   = $urandom_range(50, 200);
                stall = 0;
            end else begin
                run   = $urandom_range(1, 8);
                stall = pick_gap();
            end
            i_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input t_mode m, input logic [SEQ_W-1:0] s,
                             input logic [HANDLE_W-1:0] h, input logic p,
                             input logic [FLAG_W-1:0] f, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_mode           <= m;
        i_seq_num        <= s;
        i_handle         <= h;
        i_handle_present <= p;
        i_flag_mask      <= f;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic directed_beat(input t_mode m, input logic [SEQ_W-1:0] s,
                                 input logic [HANDLE_W-1:0] h, input logic p,
                                 input logic [FLAG_W-1:0] f);
        send_beat(m, s, h, p, f, pick_gap());
        drain_results();
    endtask

    task automatic write_start_seq(input logic [SEQ_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_directed();
        logic [SEQ_W-1:0] t0;
        t0 = seen_tail;
        directed_beat(MODE_GET, t0, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_PUT, t0, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        directed_beat(MODE_PUT, t0, 32'h1234_5678, 1'b1, 8'h00);
        directed_beat(MODE_GET, t0, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        directed_beat(MODE_PUT, t0 + 32'd63, 32'h0, 1'b1, 8'h00);
        directed_beat(MODE_PUT, t0 + 32'd64, 32'hA5A5_5A5A, 1'b1, 8'h00);
        directed_beat(MODE_GET, t0 - 32'd1, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_AND, t0 + 32'h8000_0000, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_OR, t0 + 32'h7FFF_FFFF, 32'h0, 1'b0, 8'hFF);
        directed_beat(MODE_PUT, t0 + 32'd5, 32'hDEAD_BEEF, 1'b0, 8'h00);
        directed_beat(MODE_OR, t0, 32'h0, 1'b0, 8'hFF);
        directed_beat(MODE_AND, t0, 32'h0, 1'b0, 8'h0F);
        directed_beat(MODE_PUT, t0, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_GET, t0, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_POP_FULL, 32'hFFFF_FFFF, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_OR, t0 + 32'd1, 32'h0, 1'b0, 8'hA5);
        directed_beat(MODE_PUT, t0 + 32'd1, 32'h8000_0001, 1'b1, 8'h00);
        directed_beat(MODE_POP, 32'h0, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_POP_FULL, 32'h0, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        directed_beat(MODE_SPARE, $urandom, $urandom, 1'b1, 8'hFF);
        directed_beat(MODE_AND, t0 + 32'd66, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_PUT, t0 + 32'd65, 32'h7FFF_FFFF, 1'b1, 8'h00);
        directed_beat(MODE_GET, t0 + 32'd63, 32'h0, 1'b0, 8'h00);
        directed_beat(MODE_GET, t0 + 32'd65, 32'h0, 1'b0, 8'h00);
    endtask

    task automatic issue_random_beat();
        int               r;
        int               pick;
        t_mode            m;
        logic [SEQ_W-1:0] s;
        r    = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            s = seen_tail + 32'($urandom_range(0, 15));
        end else if (pick < 9) begin
            s = seen_tail + 32'($urandom_range(0, 63));
        end else begin
            s = seen_tail + 32'($urandom_range(60, 66));
        end
        if (r < 28) begin
            m = MODE_PUT;
        end else if (r < 42) begin
            m = MODE_GET;
        end else if (r < 52) begin
            m = MODE_AND;
        end else if (r < 62) begin
            m = MODE_OR;
        end else if (r < 72) begin
            m = MODE_POP;
            s = $urandom;
        end else if (r < 86) begin
            m = MODE_POP_FULL;
            s = $urandom;
        end else if (r < 89) begin
            m = ($urandom_range(0, 1) != 0) ? MODE_QUERY : MODE_SPARE;
            s = $urandom;
        end else begin
            m    = t_mode'($urandom_range(0, 3));
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                s = seen_tail - 32'($urandom_range(1, 8));
            end else if (pick == 1) begin
                s = seen_tail + 32'($urandom_range(64, 72));
            end else begin
                s = $urandom;
            end
        end
        send_beat(m, s, $urandom, ($urandom_range(0, 9) != 0),
                  8'($urandom_range(0, 255)), quiet_input ? 0 : pick_gap());
    endtask

    task automatic run_phase(input logic [SEQ_W-1:0] base, input int count);
        drain_results();
        write_start_seq(base);
        directed_beat(MODE_QUERY, 32'h0, 32'h0, 1'b0, 8'h00);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                quiet_input = ($urandom_range(0, 3) == 0);
            end
            issue_random_beat();
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= '0;
        i_valid          <= 1'b0;
        i_mode           <= MODE_GET;
        i_seq_num        <= '0;
        i_handle         <= '0;
        i_handle_present <= 1'b0;
        i_flag_mask      <= '0;
        quiet_input       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_phase(32'hFFFF_FFF0, RANDOM_PER_PHASE);
        run_phase(32'hFFFF_FFFF, RANDOM_PER_PHASE);
        run_phase(32'h7FFF_FFC0, RANDOM_PER_PHASE);
        run_phase(32'h0000_0000, RANDOM_PER_PHASE);
        run_phase($urandom, RANDOM_PER_PHASE);
        run_phase($urandom, RANDOM_PER_PHASE);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sequence_reorder_window_unit.f
sv/srw_pkg.sv
sv/srw_ctrl.sv
sv/srw_datapath.sv
sv/sequence_reorder_window_unit.sv
sim/srw_window_checker.sv
sim/tb.sv
